// File: hdl/lcd_mode_timer_and_background_renderer_macros.svh
// Assertion helpers for the LCD timer and background renderer.
// Both sample on aclk and stay quiet while aresetn is low.
`ifndef LCD_MODE_TIMER_AND_BACKGROUND_RENDERER_MACROS_SVH
`define LCD_MODE_TIMER_AND_BACKGROUND_RENDERER_MACROS_SVH

// cond holds -> prop holds in the same cycle
`define LMTBR_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// cond holds -> prop holds in the next cycle
`define LMTBR_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: hdl/lmtbr_pkg.sv
package lmtbr_pkg;

    // Video memory geometry: two byte-wide banks (even / odd bytes)
    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = 13;
    localparam int BANK_AW    = 12;
    localparam int TILE_COUNT = 384;

    // Item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // LCD modes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_VRAM   = 2'd3;

    // Mode thresholds in dots
    localparam logic [9:0] OAM_END    = 10'd80;
    localparam logic [9:0] VRAM_END   = 10'd172;
    localparam logic [9:0] HBLANK_END = 10'd204;
    localparam logic [9:0] LINE_END   = 10'd456;
    localparam logic [9:0] DOT_MAX    = 10'd1023;

    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    // Tile map bases
    localparam logic [12:0] MAP_BASE0 = 13'h1800;
    localparam logic [12:0] MAP_BASE1 = 13'h1C00;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SCROLL_X   = 3'd0;
    localparam logic [2:0] REG_SCROLL_Y   = 3'd1;
    localparam logic [2:0] REG_MAP_SELECT = 3'd2;
    localparam logic [2:0] REG_UNSIGNED   = 3'd3;
    localparam logic [2:0] REG_PALETTE    = 3'd4;

    localparam logic [7:0] PALETTE_RESET = 8'd228;

    typedef struct packed {
        logic        operation;
        logic [12:0] address;
        logic [7:0]  data;
        logic [7:0]  cycles;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  line;
        logic        vblank_irq;
        logic        pixel_valid;
        logic [4:0]  group_index;
        logic [15:0] shades;
        logic        last;
    } out_item_t;

endpackage

// File: hdl/lcd_mode_timer_and_background_renderer.sv
// LCD mode timer and background line renderer.
// Input channel (s_valid/s_ready/s_item) carries beats of two kinds: a video
// memory byte write, or a time tick that advances the dot clock and mode.
// Output channel (m_valid/m_ready/m_item) returns one beat per tick, or
// GROUPS beats (eight 2-bit shades each, last flagged) when a tick ends
// VRAM access and the current background line is drawn.
// Configuration is an APB-style port; registers at byte offsets 0..16.
// A write returns nothing; a plain tick result appears in the output register
// the cycle after acceptance.
// A drawing tick fetches GROUPS+1 tiles, each in three steps (map byte read,
// tile row read, shade build) in states ST_MAP, ST_TILE and ST_DATA; the single
// read port of the video memory banks makes these steps run one after another.
// After reset the block sweeps all 4096 entries of both memory banks to zero,
// one word a cycle, with s_ready low; configuration writes are taken throughout.
// When the receiver stalls, the output register holds its beat; drawing
// pauses on the pending group and no new input is taken until it drains.
`include "lcd_mode_timer_and_background_renderer_macros.svh"

module lcd_mode_timer_and_background_renderer #(
    parameter int SCREEN_PIXELS = 160
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lmtbr_pkg::in_item_t   s_item,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output lmtbr_pkg::out_item_t  m_item,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import lmtbr_pkg::*;

    localparam int GROUPS = (SCREEN_PIXELS + 7) / 8;
    localparam int TCW    = $clog2(GROUPS + 1);
    localparam int REM    = SCREEN_PIXELS % 8;
    localparam int BANK_DEPTH = VRAM_BYTES / 2;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAP   = 3'd2;
    localparam logic [2:0] ST_TILE  = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;

    // Configuration registers
    logic [7:0] scroll_x_reg, scroll_y_reg, palette_reg;
    logic       map_select_reg, unsigned_tiles_reg;

    // Timing state
    logic [1:0] mode_reg, mode_next;
    logic [7:0] line_reg, line_next;
    logic [9:0] dot_reg, dot_next;

    // Sequencer
    logic [2:0]          state_reg, state_next;
    logic [BANK_AW-1:0]  clr_reg, clr_next;
    logic [TCW-1:0]      tile_cnt_reg, tile_cnt_next;
    logic                map_odd_reg, map_odd_next;
    logic [7:0]          win_lo_reg, win_lo_next, win_hi_reg, win_hi_next;

    // Output register
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_item_reg, m_item_next;

    // Video memory banks
    logic [7:0] mem_even [BANK_DEPTH];
    logic [7:0] mem_odd  [BANK_DEPTH];
    logic [7:0] rd_even_reg, rd_odd_reg;
    logic               we_even, we_odd, rd_en;
    logic [BANK_AW-1:0] wr_idx, rd_idx;
    logic [7:0]         wr_data;

    // Datapath helpers
    logic        in_fire, out_free;
    logic [10:0] clk_sum;
    logic [9:0]  clk_sat;
    logic [7:0]  line_inc;
    logic [7:0]  bg_y;
    logic [4:0]  map_col;
    logic [12:0] map_addr;
    logic [7:0]  map_byte;
    logic [8:0]  tile_ext, tile_id;
    logic [TCW-1:0] grp;
    logic        grp_last;
    logic [15:0] cat_lo, cat_hi;
    logic [7:0]  pix_lo, pix_hi;
    logic [15:0] shades;
    logic [1:0]  pix_id;

    assign pready   = 1'b1;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_valid && s_ready;

    // APB register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_x_reg       <= '0;
            scroll_y_reg       <= '0;
            map_select_reg     <= 1'b0;
            unsigned_tiles_reg <= 1'b0;
            palette_reg        <= PALETTE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                REG_SCROLL_X:   scroll_x_reg       <= pwdata[7:0];
                REG_SCROLL_Y:   scroll_y_reg       <= pwdata[7:0];
                REG_MAP_SELECT: map_select_reg     <= pwdata[0];
                REG_UNSIGNED:   unsigned_tiles_reg <= pwdata[0];
                REG_PALETTE:    palette_reg        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // APB read mux
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_SCROLL_X:   prdata = {24'd0, scroll_x_reg};
            REG_SCROLL_Y:   prdata = {24'd0, scroll_y_reg};
            REG_MAP_SELECT: prdata = {31'd0, map_select_reg};
            REG_UNSIGNED:   prdata = {31'd0, unsigned_tiles_reg};
            REG_PALETTE:    prdata = {24'd0, palette_reg};
            default:        prdata = '0;
        endcase
    end

    // Memory banks: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we_even) begin
            mem_even[wr_idx] <= wr_data;
        end
        if (we_odd) begin
            mem_odd[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_even_reg <= mem_even[rd_idx];
            rd_odd_reg  <= mem_odd[rd_idx];
        end
    end

    // Tick arithmetic
    assign clk_sum  = {1'b0, dot_reg} + {3'd0, s_item.cycles};
    assign clk_sat  = (clk_sum > {1'b0, DOT_MAX}) ? DOT_MAX : clk_sum[9:0];
    assign line_inc = line_reg + 8'd1;

    // Tile map address of the current fetch (32 map bytes per tile row)
    assign bg_y     = line_reg + scroll_y_reg;
    assign map_col  = scroll_x_reg[7:3] + 5'(tile_cnt_reg);
    assign map_addr = (map_select_reg ? MAP_BASE1 : MAP_BASE0) + {3'd0, bg_y[7:3], 5'd0}
                      + 13'(map_col);

    // Tile id from the fetched map byte, signed addressing and wrap
    assign map_byte = map_odd_reg ? rd_odd_reg : rd_even_reg;
    assign tile_ext = (!unsigned_tiles_reg && !map_byte[7]) ? {1'b1, map_byte}
                                                            : {1'b0, map_byte};
    assign tile_id  = ({1'b0, tile_ext} >= 10'(TILE_COUNT)) ? tile_ext - 9'(TILE_COUNT)
                                                            : tile_ext;

    // Group under construction
    assign grp      = tile_cnt_reg - TCW'(1);
    assign grp_last = (grp == TCW'(GROUPS - 1));
    assign cat_lo   = {win_lo_reg, rd_even_reg} << scroll_x_reg[2:0];
    assign cat_hi   = {win_hi_reg, rd_odd_reg} << scroll_x_reg[2:0];
    assign pix_lo   = cat_lo[15:8];
    assign pix_hi   = cat_hi[15:8];

    // Palette lookup per pixel, leftmost in bits 1:0
    always_comb begin
        shades = '0;
        pix_id = '0;
        for (int p = 0; p < 8; p++) begin
            pix_id = {pix_hi[7-p], pix_lo[7-p]};
            if (!(grp_last && (REM != 0) && (p >= REM))) begin
                shades[2*p +: 2] = palette_reg[2*pix_id +: 2];
            end
        end
    end

    // Timing machine, render sequencer and output register
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        tile_cnt_next = tile_cnt_reg;
        map_odd_next  = map_odd_reg;
        win_lo_next   = win_lo_reg;
        win_hi_next   = win_hi_reg;
        mode_next     = mode_reg;
        line_next     = line_reg;
        dot_next      = dot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_item_next   = m_item_reg;
        we_even       = 1'b0;
        we_odd        = 1'b0;
        wr_idx        = s_item.address[12:1];
        wr_data       = s_item.data;
        rd_en         = 1'b0;
        rd_idx        = map_addr[12:1];

        unique case (state_reg)
            ST_CLEAR: begin
                we_even  = 1'b1;
                we_odd   = 1'b1;
                wr_idx   = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + BANK_AW'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire && s_item.operation == OP_WRITE) begin
                    we_even = !s_item.address[0];
                    we_odd  = s_item.address[0];
                end else if (in_fire) begin
                    m_item_next             = '0;
                    m_item_next.last        = 1'b1;
                    dot_next                = clk_sat;
                    case (mode_reg)
                        MODE_OAM: begin
                            if (clk_sat >= OAM_END) begin
                                mode_next = MODE_VRAM;
                                dot_next  = '0;
                            end
                        end
                        MODE_VRAM: begin
                            if (clk_sat >= VRAM_END) begin
                                mode_next     = MODE_HBLANK;
                                dot_next      = '0;
                                tile_cnt_next = '0;
                                state_next    = ST_MAP;
                            end
                        end
                        MODE_HBLANK: begin
                            if (clk_sat >= HBLANK_END) begin
                                dot_next  = '0;
                                line_next = line_inc;
                                if (line_inc == VBLANK_LINE) begin
                                    mode_next              = MODE_VBLANK;
                                    m_item_next.vblank_irq = 1'b1;
                                end else begin
                                    mode_next = MODE_OAM;
                                end
                            end
                        end
                        default: begin
                            if (clk_sat >= LINE_END) begin
                                dot_next  = '0;
                                line_next = line_inc;
                                if (line_inc > LAST_LINE) begin
                                    mode_next = MODE_OAM;
                                    line_next = '0;
                                end
                            end
                        end
                    endcase
                    m_item_next.mode = mode_next;
                    m_item_next.line = line_next;
                    // a drawing tick reports through its pixel groups instead
                    if (state_next == ST_IDLE) begin
                        m_valid_next = 1'b1;
                    end else begin
                        m_item_next = m_item_reg;
                    end
                end
            end
            ST_MAP: begin
                // fetch the map byte of the next tile column
                rd_en        = 1'b1;
                rd_idx       = map_addr[12:1];
                map_odd_next = map_addr[0];
                state_next   = ST_TILE;
            end
            ST_TILE: begin
                // fetch both bit planes of the tile row
                rd_en      = 1'b1;
                rd_idx     = {tile_id, bg_y[2:0]};
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (tile_cnt_reg == '0) begin
                    win_lo_next   = rd_even_reg;
                    win_hi_next   = rd_odd_reg;
                    tile_cnt_next = tile_cnt_reg + TCW'(1);
                    state_next    = ST_MAP;
                end else if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_item_next.mode        = mode_reg;
                    m_item_next.line        = line_reg;
                    m_item_next.vblank_irq  = 1'b0;
                    m_item_next.pixel_valid = 1'b1;
                    m_item_next.group_index = 5'(grp);
                    m_item_next.shades      = shades;
                    m_item_next.last        = grp_last;
                    win_lo_next             = rd_even_reg;
                    win_hi_next             = rd_odd_reg;
                    if (grp_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        tile_cnt_next = tile_cnt_reg + TCW'(1);
                        state_next    = ST_MAP;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            tile_cnt_reg <= '0;
            mode_reg     <= MODE_OAM;
            line_reg     <= '0;
            dot_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            tile_cnt_reg <= tile_cnt_next;
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            dot_reg      <= dot_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        map_odd_reg <= map_odd_next;
        win_lo_reg  <= win_lo_next;
        win_hi_reg  <= win_hi_next;
        m_item_reg  <= m_item_next;
    end

    `LMTBR_ASSERT_IMP(a_quiet_clear, state_reg == ST_CLEAR, !m_valid_reg, "result during clear")
    `LMTBR_ASSERT_IMP(a_line_range, 1'b1, line_reg <= LAST_LINE, "line counter out of range")
    `LMTBR_ASSERT_IMP(a_tick_last, m_valid_reg && !m_item_reg.pixel_valid, m_item_reg.last, "tick result without last")
    `LMTBR_ASSERT_NXT(a_draw_start, in_fire && s_item.operation == OP_TICK && mode_reg == MODE_VRAM && clk_sat >= VRAM_END, state_reg == ST_MAP && mode_reg == MODE_HBLANK, "drawing did not start")

endmodule

// File: verif/lcd_scanline_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register channels, keeps its own copy of the
// LCD timer state and video memory, and checks every result beat in order.
module lcd_scanline_checker #(
    parameter int SCREEN_PIXELS = 160
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  lmtbr_pkg::in_item_t  s_item,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  lmtbr_pkg::out_item_t m_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   results_owed
);
    import lmtbr_pkg::*;

    localparam int GROUPS    = (SCREEN_PIXELS + 7) / 8;
    localparam int MAX_LINES = 40;

    // mirrored block state
    logic [7:0]  vram [0:VRAM_BYTES-1];
    logic [1:0]  lcd_mode_q;
    logic [7:0]  line_q;
    int unsigned dots;

    // mirrored registers
    logic [7:0] scx;
    logic [7:0] scy;
    logic       map_hi;
    logic       tiles_unsigned;
    logic [7:0] pal;

    out_item_t owed_q[$];
    int        beat_no;

    initial begin
        mismatches   = 0;
        results_owed = 0;
        beat_no      = 0;
    end

    task automatic report(input string what);
        if (mismatches < MAX_LINES)
            $display("[%0t] result beat %0d: %s", $time, beat_no, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // tile id at a map row and column, with signed addressing folded in
    function automatic int unsigned tile_at(input int unsigned map_row,
                                            input int unsigned col);
        int unsigned t;
        t = vram[(map_row + (col & 31)) & (VRAM_BYTES - 1)];
        if (!tiles_unsigned && t < 128)
            t += 256;
        return t % TILE_COUNT;
    endfunction

    // one background line as GROUPS beats of eight shades
    task automatic render_bg_line();
        int unsigned y, row, map_row, col, tx, tile, lo, hi, cid, x;
        int          g, p;
        logic [15:0] sh;
        out_item_t   r;
        y       = (line_q + scy) & 8'hFF;
        row     = y & 7;
        map_row = (map_hi ? MAP_BASE1 : MAP_BASE0) + ((y >> 3) << 5);
        col     = scx >> 3;
        tx      = scx & 7;
        tile    = tile_at(map_row, col);
        for (g = 0; g < GROUPS; g++) begin
            sh = '0;
            for (p = 0; p < 8; p++) begin
                x = g * 8 + p;
                if (x < SCREEN_PIXELS) begin
                    lo  = vram[(tile * 16 + row * 2) & (VRAM_BYTES - 1)];
                    hi  = vram[(tile * 16 + row * 2 + 1) & (VRAM_BYTES - 1)];
                    cid = ((lo >> (7 - tx)) & 1) | (((hi >> (7 - tx)) & 1) << 1);
                    sh[2*p +: 2] = pal[2*cid +: 2];
                    tx++;
                    if (tx == 8) begin
                        tx   = 0;
                        col  = (col + 1) & 31;
                        tile = tile_at(map_row, col);
                    end
                end
            end
            r.mode        = lcd_mode_q;
            r.line        = line_q;
            r.vblank_irq  = 1'b0;
            r.pixel_valid = 1'b1;
            r.group_index = 5'(g);
            r.shades      = sh;
            r.last        = (g == GROUPS - 1);
            owed_q.push_back(r);
        end
    endtask

    // advance the timer by one accepted item, queue what it returns
    task automatic lcd_step(input in_item_t it);
        logic      irq;
        out_item_t r;
        irq = 1'b0;
        if (it.operation == OP_WRITE) begin
            vram[it.address] = it.data;
            return;
        end
        dots = dots + it.cycles;
        if (dots > DOT_MAX)
            dots = DOT_MAX;
        case (lcd_mode_q)
            MODE_OAM: begin
                if (dots >= OAM_END) begin
                    lcd_mode_q = MODE_VRAM;
                    dots       = 0;
                end
            end
            MODE_VRAM: begin
                if (dots >= VRAM_END) begin
                    lcd_mode_q = MODE_HBLANK;
                    dots       = 0;
                    render_bg_line();
                    return;
                end
            end
            MODE_HBLANK: begin
                if (dots >= HBLANK_END) begin
                    dots   = 0;
                    line_q = line_q + 8'd1;
                    if (line_q == VBLANK_LINE) begin
                        lcd_mode_q = MODE_VBLANK;
                        irq        = 1'b1;
                    end else begin
                        lcd_mode_q = MODE_OAM;
                    end
                end
            end
            default: begin
                if (dots >= LINE_END) begin
                    dots   = 0;
                    line_q = line_q + 8'd1;
                    if (line_q > LAST_LINE) begin
                        lcd_mode_q = MODE_OAM;
                        line_q     = '0;
                    end
                end
            end
        endcase
        r             = '0;
        r.mode        = lcd_mode_q;
        r.line        = line_q;
        r.vblank_irq  = irq;
        r.last        = 1'b1;
        owed_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int a = 0; a < VRAM_BYTES; a++)
                vram[a] = '0;
            lcd_mode_q     = MODE_OAM;
            line_q         = '0;
            dots           = 0;
            scx            = '0;
            scy            = '0;
            map_hi         = 1'b0;
            tiles_unsigned = 1'b0;
            pal            = PALETTE_RESET;
            owed_q.delete();
            results_owed <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_SCROLL_X:   scx            = pwdata[7:0];
                    REG_SCROLL_Y:   scy            = pwdata[7:0];
                    REG_MAP_SELECT: map_hi         = pwdata[0];
                    REG_UNSIGNED:   tiles_unsigned = pwdata[0];
                    REG_PALETTE:    pal            = pwdata[7:0];
                    default: ;
                endcase
            end
            // result beats, oldest expectation first
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    report("no result expected");
                end else begin
                    want = owed_q.pop_front();
                    check_field("mode", m_item.mode, want.mode);
                    check_field("line", m_item.line, want.line);
                    check_field("vblank_irq", m_item.vblank_irq, want.vblank_irq);
                    check_field("pixel_valid", m_item.pixel_valid, want.pixel_valid);
                    check_field("group_index", m_item.group_index, want.group_index);
                    check_field("shades", m_item.shades, want.shades);
                    check_field("last", m_item.last, want.last);
                end
                beat_no++;
            end
            // input beats
            if (s_valid && s_ready)
                lcd_step(s_item);
            results_owed <= owed_q.size();
        end
    end

endmodule

// File: verif/lcd_mode_timer_and_background_renderer_tb.sv
`timescale 1ns / 1ps

module lcd_mode_timer_and_background_renderer_tb;
    import lmtbr_pkg::*;

    localparam int SCREEN_PIXELS   = 160;
    localparam int TRAILING_CYCLES = 70;
    // the reset sweep of both memory banks is the longest quiet stretch
    localparam int QUIET_LIMIT     = 20000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int results_owed;
    logic idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned quiet = 0;

    always #5 aclk = ~aclk;

    lcd_mode_timer_and_background_renderer #(
        .SCREEN_PIXELS(SCREEN_PIXELS)
    ) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lcd_scanline_checker #(
        .SCREEN_PIXELS(SCREEN_PIXELS)
    ) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .results_owed(results_owed)
    );

    // receiver stalls at random, in bursts, while idle_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_item_t mk(input logic op, input logic [12:0] addr,
                                    input logic [7:0] dat, input logic [7:0] cyc);
        in_item_t it;
        it.operation = op;
        it.address   = addr;
        it.data      = dat;
        it.cycles    = cyc;
        return it;
    endfunction

    // writes lean on a few tiles and the maps so drawn lines carry content
    function automatic in_item_t rand_write();
        in_item_t    it;
        int unsigned pick;
        logic [8:0]  hot;
        it = mk(OP_WRITE, 13'($urandom), 8'($urandom), 8'($urandom));
        case ($urandom_range(0, 6))
            0:       hot = 9'd0;
            1:       hot = 9'd1;
            2:       hot = 9'd128;
            3:       hot = 9'd255;
            4:       hot = 9'd256;
            5:       hot = 9'd257;
            default: hot = 9'd383;
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            it.address = {hot, 4'($urandom_range(0, 15))};
        end else if (pick < 6) begin
            it.address = MAP_BASE0 + 13'($urandom_range(0, 2047));
            it.data    = hot[7:0];
        end
        return it;
    endfunction

    function automatic in_item_t rand_tick();
        in_item_t    it;
        int unsigned pick;
        it   = mk(OP_TICK, 13'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            it.cycles = 8'($urandom_range(150, 255));
        else if (pick < 6)
            it.cycles = 8'($urandom_range(0, 40));
        return it;
    endfunction

    // one input beat, with an optional sender gap ahead of it
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic apply_settings(input logic [7:0] sx, input logic [7:0] sy,
                                  input logic ms, input logic ut,
                                  input logic [7:0] pal);
        write_reg(REG_SCROLL_X, sx);
        write_reg(REG_SCROLL_Y, sy);
        write_reg(REG_MAP_SELECT, {7'd0, ms});
        write_reg(REG_UNSIGNED, {7'd0, ut});
        write_reg(REG_PALETTE, pal);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let every owed result drain, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (TRAILING_CYCLES) @(posedge aclk);
    endtask

    task automatic run_mixed(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 35)
                send_item(rand_write());
            else
                send_item(rand_tick());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: memory extremes, a few tiles, exact thresholds
        apply_settings(8'd0, 8'd0, 1'b0, 1'b0, PALETTE_RESET);
        send_item(mk(OP_WRITE, 13'h0000, 8'h00, 8'hFF));
        send_item(mk(OP_WRITE, 13'h1FFF, 8'hFF, 8'h00));
        send_item(mk(OP_WRITE, 13'h1000, 8'hAA, 8'h00));
        send_item(mk(OP_WRITE, 13'h1001, 8'h55, 8'h00));
        send_item(mk(OP_WRITE, 13'h17F0, 8'h0F, 8'h00));
        send_item(mk(OP_WRITE, 13'h17F1, 8'hF0, 8'h00));
        send_item(mk(OP_WRITE, 13'h1801, 8'h7F, 8'h00));
        send_item(mk(OP_WRITE, 13'h1802, 8'h80, 8'h00));
        send_item(mk(OP_WRITE, 13'h0800, 8'hFF, 8'h00));
        send_item(mk(OP_WRITE, 13'h1C00, 8'hFF, 8'h00));
        send_item(mk(OP_TICK, 13'h1FFF, 8'hFF, 8'd0));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd79));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd1));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd171));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd1));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd255));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd255));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd255));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd203));
        send_item(mk(OP_TICK, 13'h0000, 8'h00, 8'd1));
        drain();

        // random phases over several register settings
        apply_settings(8'd255, 8'd255, 1'b1, 1'b1, 8'hFF);
        run_mixed(45);
        drain();

        apply_settings(8'd7, 8'd8, 1'b0, 1'b1, 8'h00);
        run_mixed(45);
        drain();

        idle_on = 1'b0;
        apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 8'h1B);
        run_mixed(45);
        drain();

        idle_on = 1'b1;
        apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                       8'($urandom));
        run_mixed(45);
        drain();

        // at speed: long ticks move the mode on with every tick outside VBLANK
        idle_on = 1'b0;
        apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                       8'($urandom));
        for (int i = 0; i < 70; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(rand_write());
            send_item(mk(OP_TICK, 13'($urandom), 8'($urandom),
                         8'($urandom_range(228, 255))));
        end
        drain();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
